/* hw/rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the bitmap block allocator: field widths,
// request and status codes, register indexes and the controller states.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Payload field widths
   localparam int FUNC_W   = 1;
   localparam int COUNT_W  = 5;
   localparam int BLOCK_W  = 12;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 13;

   // Block positions inside the search window, and occupancy map words
   localparam int POS_W    = 13;
   localparam int WORD_W   = 32;
   localparam int BIT_W    = 5;
   localparam int WIDX_W   = POS_W - BIT_W;
   localparam int POS_SPAN = 1 << POS_W;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Request codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

   // Register indexes (taken from paddr bit 2)
   localparam logic REG_DATA_START   = 1'b0;
   localparam logic REG_TOTAL_BLOCKS = 1'b1;

   // Register reset values
   localparam logic [BLOCK_W-1:0] DATA_START_RST   = 12'd1;
   localparam logic [TOTAL_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COUNT,
      ST_MARK_RD,
      ST_MARK_LD,
      ST_MARK_SCAN,
      ST_FREE_RD,
      ST_FREE_WB,
      ST_RESP
   } bba_state_type;

endpackage

/* hw/rtl/bba_req_if.sv */
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel of the block allocator: valid/ready plus one request word.
// ----------------------------------------------------------------------------
interface bba_req_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::FUNC_W-1:0]    func;
   logic [bba_pkg::COUNT_W-1:0]   count;
   logic [bba_pkg::BLOCK_W-1:0]   block;

   modport source (output valid, output func, output count, output block, input ready);
   modport sink   (input valid, input func, input count, input block, output ready);
endinterface

/* hw/rtl/bba_rsp_if.sv */
// ----------------------------------------------------------------------------
// bba_rsp_if
// Result channel of the block allocator: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::BLOCK_W-1:0]   block_number;
   logic [bba_pkg::STATUS_W-1:0]  status;
   logic                          last;

   modport source (output valid, output block_number, output status, output last,
                   input ready);
   modport sink   (input valid, input block_number, input status, input last,
                   output ready);
endinterface

/* hw/rtl/bitmap_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a one-bit-per-block occupancy map held in a
// synchronous RAM of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request word: func selects allocate (count blocks)
//   or free (one block). rsp_chan returns one word per allocated block in
//   ascending order, last set on the final one; a free, a bad request or a
//   failed allocate returns a single word with last set.
//   csr_* is an APB-style port: data_start at byte 0, total_blocks at 4.
// Timing:
//   A free reads its map word, then writes it back with the bit cleared
//   as its result goes out; a bad request goes straight to its result. An
//   allocate first counts free blocks, one map word per cycle from the word
//   of data_start until enough are found, then marks them: each map word
//   visited is read, loaded and scanned for free blocks, lowest first, and
//   written back once it has none left or with the last block. One request
//   is worked on at a time; the next is taken as soon as the last result
//   word sits in the output register, even while it waits to be taken.
// Reset:
//   Registers return to data_start 1, total_blocks 4096. The map is then
//   cleared one word a cycle, NUM_WORDS words (128 at the default size);
//   no request is taken meanwhile. A stalled receiver holds the output word
//   and pauses the allocator.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
   parameter int NUM_BLOCKS = 4096,
   parameter int MAX_RUN    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   bba_req_if.sink                            req_chan,
   bba_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   // Map size actually reachable by the 13-bit search window
   localparam int MAP_BLOCKS = (NUM_BLOCKS < bba_pkg::POS_SPAN) ? NUM_BLOCKS
                                                                : bba_pkg::POS_SPAN;
   localparam int NUM_WORDS  = (MAP_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
   localparam int ADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam logic [bba_pkg::POS_W:0]  MAP_LIM  = (bba_pkg::POS_W + 1)'(MAP_BLOCKS);
   localparam logic [16:0]              NB_LIM   = 17'(NUM_BLOCKS);
   localparam logic [6:0]               RUN_LIM  = 7'(MAX_RUN);
   localparam logic [ADDR_W-1:0]        CLR_LAST = ADDR_W'(NUM_WORDS - 1);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   bba_pkg::bba_state_type               state_ff, state_in;
   logic [bba_pkg::BLOCK_W-1:0]          data_start_ff, data_start_in;
   logic [bba_pkg::TOTAL_W-1:0]          total_blocks_ff, total_blocks_in;
   logic [ADDR_W-1:0]                    clr_ff, clr_in;
   logic                                 dval_ff, dval_in;
   logic                                 iss_done_ff, iss_done_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   logic [bba_pkg::BLOCK_W-1:0]          blk_ff, blk_in;
   logic [bba_pkg::COUNT_W-1:0]          cnt_ff, cnt_in;
   logic [bba_pkg::STATUS_W-1:0]         resp_stat_ff, resp_stat_in;
   logic [bba_pkg::WIDX_W-1:0]           scan_ff, scan_in;
   logic [bba_pkg::WIDX_W-1:0]           dword_ff, dword_in;
   logic [bba_pkg::COUNT_W-1:0]          nfree_ff, nfree_in;
   logic [bba_pkg::WIDX_W-1:0]           mk_word_ff, mk_word_in;
   logic [bba_pkg::COUNT_W-1:0]          left_ff, left_in;
   logic [bba_pkg::WORD_W-1:0]           word_ff, word_in;
   logic [bba_pkg::BLOCK_W-1:0]          rsp_block_ff;
   logic [bba_pkg::STATUS_W-1:0]         rsp_status_ff;
   logic                                 rsp_last_ff;

   // Occupancy map RAM
   logic [bba_pkg::WORD_W-1:0]           map_mem [NUM_WORDS];
   logic [bba_pkg::WORD_W-1:0]           rd_data_ff;

   // ------------------------------------------------------------------------
   // Combinational signals
   // ------------------------------------------------------------------------
   logic                                 req_fire;
   logic                                 out_free;
   logic                                 csr_wr;
   logic [bba_pkg::POS_W-1:0]            lim;
   logic [bba_pkg::POS_W-1:0]            lim_m1;
   logic [bba_pkg::WIDX_W-1:0]           last_word;
   logic [bba_pkg::WIDX_W-1:0]           ds_word;
   logic                                 win_empty;
   logic                                 count_bad;
   logic                                 free_bad;
   logic [bba_pkg::WORD_W-1:0]           cnt_free;
   logic [5:0]                           pop;
   logic [5:0]                           nsum;
   logic                                 enough;
   logic [bba_pkg::WORD_W-1:0]           mk_free;
   logic [bba_pkg::WORD_W-1:0]           mk_iso;
   logic [bba_pkg::BIT_W-1:0]            mk_bit;
   logic [bba_pkg::POS_W-1:0]            mk_pos;
   logic [bba_pkg::WORD_W-1:0]           free_clr;

   logic                                 mem_re;
   logic [ADDR_W-1:0]                    mem_raddr;
   logic                                 mem_we;
   logic [ADDR_W-1:0]                    mem_waddr;
   logic [bba_pkg::WORD_W-1:0]           mem_wdata;
   logic                                 emit;
   logic [bba_pkg::BLOCK_W-1:0]          emit_block;
   logic [bba_pkg::STATUS_W-1:0]         emit_status;
   logic                                 emit_last;

   // Window bits of one map word: at or above data_start, below the limit
   function automatic logic [bba_pkg::WORD_W-1:0] win_mask(
      input logic [bba_pkg::WIDX_W-1:0]  widx,
      input logic [bba_pkg::BLOCK_W-1:0] ds,
      input logic [bba_pkg::POS_W-1:0]   lm
   );
      logic [bba_pkg::WORD_W-1:0] lo;
      logic [bba_pkg::WORD_W-1:0] hi;
      lo = '1;
      hi = '1;
      if (widx == {1'b0, ds[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W]}) begin
         lo = {bba_pkg::WORD_W{1'b1}} << ds[bba_pkg::BIT_W-1:0];
      end
      if (widx == lm[bba_pkg::POS_W-1:bba_pkg::BIT_W]) begin
         hi = ({{(bba_pkg::WORD_W-1){1'b0}}, 1'b1} << lm[bba_pkg::BIT_W-1:0])
              - {{(bba_pkg::WORD_W-1){1'b0}}, 1'b1};
      end
      return lo & hi;
   endfunction

   // ------------------------------------------------------------------------
   // Handshakes and configuration port
   // ------------------------------------------------------------------------
   assign req_chan.ready = (state_ff == bba_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.block_number = rsp_block_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.last         = rsp_last_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Return the addressed register
   always_comb begin
      unique case (csr_paddr[2])
         bba_pkg::REG_DATA_START:
            csr_prdata = {{(bba_pkg::CSR_DATA_W-bba_pkg::BLOCK_W){1'b0}}, data_start_ff};
         bba_pkg::REG_TOTAL_BLOCKS:
            csr_prdata = {{(bba_pkg::CSR_DATA_W-bba_pkg::TOTAL_W){1'b0}}, total_blocks_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // Update registers on a completed write
   always_comb begin
      data_start_in   = data_start_ff;
      total_blocks_in = total_blocks_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            bba_pkg::REG_DATA_START:   data_start_in   = csr_pwdata[bba_pkg::BLOCK_W-1:0];
            bba_pkg::REG_TOTAL_BLOCKS: total_blocks_in = csr_pwdata[bba_pkg::TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Window bounds and request checks
   // ------------------------------------------------------------------------
   always_comb begin
      if ({1'b0, total_blocks_ff} > MAP_LIM) begin
         lim = MAP_LIM[bba_pkg::POS_W-1:0];
      end else begin
         lim = total_blocks_ff;
      end
      lim_m1    = lim - {{(bba_pkg::POS_W-1){1'b0}}, 1'b1};
      last_word = lim_m1[bba_pkg::POS_W-1:bba_pkg::BIT_W];
      ds_word   = {1'b0, data_start_ff[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W]};
      win_empty = ({1'b0, data_start_ff} >= lim);
      count_bad = (req_chan.count == '0) || ({2'b00, req_chan.count} > RUN_LIM);
      free_bad  = ({1'b0, req_chan.block} >= total_blocks_ff)
                  || ({5'b0, req_chan.block} >= NB_LIM);
   end

   // ------------------------------------------------------------------------
   // Word datapath: free count for the first pass, lowest free bit for marking
   // ------------------------------------------------------------------------
   always_comb begin
      cnt_free = ~rd_data_ff & win_mask(dword_ff, data_start_ff, lim);
      pop      = 6'($countones(cnt_free));
      nsum     = {1'b0, nfree_ff} + pop;
      enough   = (nsum >= {1'b0, cnt_ff});

      mk_free  = ~word_ff & win_mask(mk_word_ff, data_start_ff, lim);
      mk_iso   = mk_free & (~mk_free + {{(bba_pkg::WORD_W-1){1'b0}}, 1'b1});
      mk_bit   = '0;
      for (int b = 0; b < bba_pkg::WORD_W; b++) begin
         if (mk_iso[b]) begin
            mk_bit = mk_bit | bba_pkg::BIT_W'(b);
         end
      end
      mk_pos   = {mk_word_ff, mk_bit};

      free_clr = ~({{(bba_pkg::WORD_W-1){1'b0}}, 1'b1} << blk_ff[bba_pkg::BIT_W-1:0]);
   end

   // ------------------------------------------------------------------------
   // Controller: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = bba_pkg::ST_IDLE;
         end
         bba_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (req_chan.func == bba_pkg::FUNC_FREE) begin
                  state_in = free_bad ? bba_pkg::ST_RESP : bba_pkg::ST_FREE_RD;
               end else if (count_bad || win_empty) begin
                  state_in = bba_pkg::ST_RESP;
               end else begin
                  state_in = bba_pkg::ST_COUNT;
               end
            end
         end
         bba_pkg::ST_COUNT: begin
            if (dval_ff) begin
               priority if (enough) begin
                  state_in = bba_pkg::ST_MARK_RD;
               end else if (dword_ff == last_word) begin
                  state_in = bba_pkg::ST_RESP;
               end else begin
                  state_in = bba_pkg::ST_COUNT;
               end
            end
         end
         bba_pkg::ST_MARK_RD:   state_in = bba_pkg::ST_MARK_LD;
         bba_pkg::ST_MARK_LD:   state_in = bba_pkg::ST_MARK_SCAN;
         bba_pkg::ST_MARK_SCAN: begin
            priority if (mk_free == '0) begin
               state_in = bba_pkg::ST_MARK_RD;
            end else if (out_free && (left_ff == bba_pkg::COUNT_W'(1))) begin
               state_in = bba_pkg::ST_IDLE;
            end else begin
               state_in = bba_pkg::ST_MARK_SCAN;
            end
         end
         bba_pkg::ST_FREE_RD:   state_in = bba_pkg::ST_FREE_WB;
         bba_pkg::ST_FREE_WB: begin
            if (out_free) state_in = bba_pkg::ST_IDLE;
         end
         bba_pkg::ST_RESP: begin
            if (out_free) state_in = bba_pkg::ST_IDLE;
         end
         default:               state_in = bba_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Controller: RAM port and result word. No state both reads and writes
   // the map, so reads never race writes.
   // ------------------------------------------------------------------------
   always_comb begin
      mem_re      = 1'b0;
      mem_raddr   = '0;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      emit        = 1'b0;
      emit_block  = '0;
      emit_status = bba_pkg::STAT_OK;
      emit_last   = 1'b1;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         bba_pkg::ST_COUNT: begin
            mem_re    = !iss_done_ff;
            mem_raddr = ADDR_W'(scan_ff);
         end
         bba_pkg::ST_MARK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(mk_word_ff);
         end
         bba_pkg::ST_MARK_SCAN: begin
            priority if (mk_free == '0) begin
               mem_we    = 1'b1;
               mem_waddr = ADDR_W'(mk_word_ff);
               mem_wdata = word_ff;
            end else if (out_free) begin
               emit       = 1'b1;
               emit_block = mk_pos[bba_pkg::BLOCK_W-1:0];
               emit_last  = (left_ff == bba_pkg::COUNT_W'(1));
               mem_we     = emit_last;
               mem_waddr  = ADDR_W'(mk_word_ff);
               mem_wdata  = word_ff | mk_iso;
            end else begin
               emit = 1'b0;
            end
         end
         bba_pkg::ST_FREE_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(blk_ff[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W]);
         end
         bba_pkg::ST_FREE_WB: begin
            if (out_free) begin
               mem_we     = 1'b1;
               mem_waddr  = ADDR_W'(blk_ff[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W]);
               mem_wdata  = rd_data_ff & free_clr;
               emit       = 1'b1;
               emit_block = blk_ff;
            end
         end
         bba_pkg::ST_RESP: begin
            emit        = out_free;
            emit_status = resp_stat_ff;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      clr_in       = clr_ff;
      dval_in      = mem_re && (state_ff == bba_pkg::ST_COUNT);
      iss_done_in  = iss_done_ff;
      blk_in       = blk_ff;
      cnt_in       = cnt_ff;
      resp_stat_in = resp_stat_ff;
      scan_in      = scan_ff;
      dword_in     = scan_ff;
      nfree_in     = nfree_ff;
      mk_word_in   = mk_word_ff;
      left_in      = left_ff;
      word_in      = word_ff;

      // Hold or advance the output register
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
         end
         bba_pkg::ST_IDLE: begin
            // Capture the request and prime the counting pass
            blk_in       = req_chan.block;
            cnt_in       = req_chan.count;
            resp_stat_in = (req_chan.func == bba_pkg::FUNC_FREE || count_bad)
                           ? bba_pkg::STAT_INVALID : bba_pkg::STAT_NOSPACE;
            scan_in      = ds_word;
            iss_done_in  = 1'b0;
            nfree_in     = '0;
         end
         bba_pkg::ST_COUNT: begin
            if (mem_re) begin
               scan_in     = scan_ff + bba_pkg::WIDX_W'(1);
               iss_done_in = (scan_ff == last_word);
            end
            if (dval_ff) begin
               nfree_in   = enough ? cnt_ff : nsum[bba_pkg::COUNT_W-1:0];
               mk_word_in = ds_word;
               left_in    = cnt_ff;
            end
         end
         bba_pkg::ST_MARK_LD: begin
            word_in = rd_data_ff;
         end
         bba_pkg::ST_MARK_SCAN: begin
            priority if (mk_free == '0) begin
               mk_word_in = mk_word_ff + bba_pkg::WIDX_W'(1);
            end else if (emit) begin
               word_in = word_ff | mk_iso;
               left_in = left_ff - bba_pkg::COUNT_W'(1);
            end else begin
               word_in = word_ff;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bba_pkg::ST_CLEAR;
         data_start_ff   <= bba_pkg::DATA_START_RST;
         total_blocks_ff <= bba_pkg::TOTAL_BLOCKS_RST;
         clr_ff          <= '0;
         dval_ff         <= 1'b0;
         iss_done_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         data_start_ff   <= data_start_in;
         total_blocks_ff <= total_blocks_in;
         clr_ff          <= clr_in;
         dval_ff         <= dval_in;
         iss_done_ff     <= iss_done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      blk_ff       <= blk_in;
      cnt_ff       <= cnt_in;
      resp_stat_ff <= resp_stat_in;
      scan_ff      <= scan_in;
      dword_ff     <= dword_in;
      nfree_ff     <= nfree_in;
      mk_word_ff   <= mk_word_in;
      left_ff      <= left_in;
      word_ff      <= word_in;
      if (emit) begin
         rsp_block_ff  <= emit_block;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   // ------------------------------------------------------------------------
   // Occupancy map RAM: one write port, one registered read port
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_raddr];
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // Read and write never hit the same word in one cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("map read and write collide on one word");

   // The marking pass never walks past the window: the count pass proved room
   a_mark_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::ST_MARK_RD) |-> (mk_word_ff <= last_word))
      else $error("marking pass ran past the search window");

   // A marking pass always has blocks left to hand out
   a_mark_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::ST_MARK_SCAN) |-> (left_ff != '0))
      else $error("marking pass with no blocks left");

   // A failed request gives a zero block number and closes the request
   a_fail_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != bba_pkg::STAT_OK))
      |-> ((rsp_block_ff == '0) && rsp_last_ff))
      else $error("failure result with block number or without last");

   // No request is taken before the map clear finishes
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == bba_pkg::ST_CLEAR) && (state_ff == bba_pkg::ST_CLEAR)
      |-> !req_chan.ready)
      else $error("request taken during map clear");

endmodule
